// ===== rtl/ymcr_pkg.sv =====
// Shared types, codes and helpers for the YMODEM-CRC receiver.
// No dependencies; every other file in rtl/ imports this package.
package ymcr_pkg;

  // Default geometry handed down from the top level
  localparam int LONG_PAYLOAD_DEF = 1024;
  localparam int TIMER_BITS_DEF   = 16;
  localparam int SHORT_PAYLOAD    = 128;
  localparam int MAX_RES          = 8;
  localparam int RES_CNT_W        = 4;

  // Link control bytes
  localparam logic [7:0] C_SOH = 8'h01;
  localparam logic [7:0] C_STX = 8'h02;
  localparam logic [7:0] C_EOT = 8'h04;
  localparam logic [7:0] C_ACK = 8'h06;
  localparam logic [7:0] C_NAK = 8'h15;
  localparam logic [7:0] C_CAN = 8'h18;
  localparam logic [7:0] C_REQ = 8'h43;
  localparam logic [7:0] C_ABORT_UC = 8'h41;
  localparam logic [7:0] C_ABORT_LC = 8'h61;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_REPLY   = 2'd1;
  localparam logic [1:0] KIND_EVENT   = 2'd2;

  // Session event codes
  localparam logic [7:0] EV_START        = 8'd1;
  localparam logic [7:0] EV_COMMIT       = 8'd2;
  localparam logic [7:0] EV_DISCARD      = 8'd3;
  localparam logic [7:0] EV_FINISH       = 8'd4;
  localparam logic [7:0] EV_FINISH_NOEND = 8'd5;
  localparam logic [7:0] EV_CANCEL       = 8'd6;
  localparam logic [7:0] EV_ABORT        = 8'd7;
  localparam logic [7:0] EV_ERRORS       = 8'd8;
  localparam logic [7:0] EV_RXTIMEOUT    = 8'd9;
  localparam logic [7:0] EV_STARTFAIL    = 8'd10;
  localparam logic [7:0] EV_WINDOW       = 8'd11;

  // Configuration register indexes
  localparam logic [2:0] CFG_MAX_ERRORS = 3'd0;
  localparam logic [2:0] CFG_RX_TO      = 3'd1;
  localparam logic [2:0] CFG_END_TO     = 3'd2;
  localparam logic [2:0] CFG_ARM_WIN    = 3'd3;
  localparam logic [2:0] CFG_HS_REPEAT  = 3'd4;
  localparam logic [2:0] CFG_IMG_LIMIT  = 3'd5;

  // Header parse phases
  localparam logic [1:0] HP_NAME   = 2'd0;
  localparam logic [1:0] HP_SPACE  = 2'd1;
  localparam logic [1:0] HP_DIGITS = 2'd2;
  localparam logic [1:0] HP_DONE   = 2'd3;

  typedef enum logic [2:0] {
    PH_HEAD   = 3'd0,
    PH_SEQ    = 3'd1,
    PH_SEQINV = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRCHI  = 3'd4,
    PH_CRCLO  = 3'd5,
    PH_SKIP   = 3'd6
  } rx_phase_t;

  typedef enum logic {
    ENG_FETCH = 1'b0,
    ENG_DIV   = 1'b1
  } eng_state_t;

  // Classified input word
  typedef struct packed {
    logic       is_tick;
    logic       is_can;
    logic       is_abort;
    logic       is_start;
    logic       is_eot;
    logic [7:0] rx_byte;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } res_t;

  typedef struct packed {
    logic [7:0]  max_errors;
    logic [15:0] rx_timeout_ms;
    logic [15:0] end_packet_timeout_ms;
    logic [15:0] arm_window_ms;
    logic [15:0] handshake_repeat_ms;
    logic [24:0] image_limit_bytes;
  } cfg_t;

  // CRC16, polynomial 0x1021, one byte MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/ymcr_front.sv =====
// Front end: accepts input words, classifies them and queues them for the engine.
// Depends on ymcr_pkg.
module ymcr_front import ymcr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_rx_byte,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  localparam int DEPTH = 4;

  cmd_t       q_r [DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cls;

  // Classify the incoming word
  always_comb begin
    cls.is_tick  = in_func;
    cls.rx_byte  = in_rx_byte;
    cls.is_can   = !in_func && (in_rx_byte == C_CAN);
    cls.is_abort = !in_func && ((in_rx_byte == C_ABORT_UC) || (in_rx_byte == C_ABORT_LC));
    cls.is_start = !in_func && ((in_rx_byte == C_SOH) || (in_rx_byte == C_STX));
    cls.is_eot   = !in_func && (in_rx_byte == C_EOT);
  end

  assign in_ready  = (cnt_r != 3'(DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 3'd0);
  assign cmd       = q_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 2'd1 : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + 2'd1 : rd_ptr_r;
    cnt_nxt    = cnt_r + 3'(push) - 3'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== rtl/ymcr_emit.sv =====
// Result stage: holds the word list of one step and hands it out one word a cycle while out_ready is high.
// Depends on ymcr_pkg.
module ymcr_emit import ymcr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  res_t [MAX_RES-1:0]        lst,
  input  logic [RES_CNT_W-1:0]      lst_n,
  output logic                      em_free,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_value,
  output logic                      out_last
);

  res_t       list_r [MAX_RES];
  logic       busy_r, busy_nxt;
  logic [2:0] ptr_r, ptr_nxt;
  logic [2:0] last_r, last_nxt;
  logic       take;

  assign out_valid = busy_r;
  assign out_kind  = list_r[ptr_r].kind;
  assign out_value = list_r[ptr_r].value;
  assign out_last  = (ptr_r == last_r);
  assign take      = busy_r && out_ready;
  assign em_free   = !busy_r || (take && out_last);

  // Drain one word a cycle while out_ready is high, reload from the engine
  always_comb begin
    busy_nxt = busy_r;
    ptr_nxt  = ptr_r;
    last_nxt = last_r;
    if (take) begin
      if (out_last) begin
        busy_nxt = 1'b0;
      end else begin
        ptr_nxt = ptr_r + 3'd1;
      end
    end
    if (load && (lst_n != '0)) begin
      busy_nxt = 1'b1;
      ptr_nxt  = 3'd0;
      last_nxt = 3'(lst_n - RES_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ptr_r  <= 3'd0;
      last_r <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      ptr_r  <= ptr_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        list_r[i] <= lst[i];
      end
    end
  end

endmodule

// ===== rtl/ymcr_engine.sv =====
// Protocol engine: packet assembly, CRC, header parse, timers and replies.
// Depends on ymcr_pkg; fed by ymcr_front, drains into ymcr_emit.
module ymcr_engine import ymcr_pkg::*; #(
  parameter int LONG_PAYLOAD = LONG_PAYLOAD_DEF,
  parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 cmd_valid,
  input  cmd_t                 cmd,
  output logic                 cmd_pop,
  input  logic                 em_free,
  output logic                 load,
  output res_t [MAX_RES-1:0]   lst,
  output logic [RES_CNT_W-1:0] lst_n
);

  localparam int IDX_W = $clog2(LONG_PAYLOAD + 3);
  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam int CNT_W = $clog2(TIMER_BITS + 1);
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  // Protocol state
  rx_phase_t             rx_phase_r, rx_phase_nxt;
  logic                  long_r, long_nxt;
  logic [IDX_W-1:0]      data_index_r, data_index_nxt;
  logic [IDX_W-1:0]      skip_r, skip_nxt;
  logic [7:0]            seq_r, seq_nxt;
  logic [15:0]           crc_r, crc_nxt;
  logic [15:0]           crc_rx_r, crc_rx_nxt;
  logic [7:0]            exp_seq_r, exp_seq_nxt;
  logic                  fc_r, fc_nxt;
  logic                  eot_pend_r, eot_pend_nxt;
  logic                  session_r, session_nxt;
  logic [7:0]            err_r, err_nxt;
  logic                  armed_r, armed_nxt;
  logic                  prev_can_r, prev_can_nxt;
  logic [TIMER_BITS-1:0] ms_arm_r, ms_arm_nxt;
  logic [TIMER_BITS-1:0] ms_rx_r, ms_rx_nxt;
  logic [TIMER_BITS-1:0] ms_eot2_r, ms_eot2_nxt;
  logic                  eot2_r, eot2_nxt;
  logic [1:0]            hp_r, hp_nxt;
  logic [31:0]           dsize_r, dsize_nxt;
  logic [24:0]           fsize_r, fsize_nxt;
  logic [31:0]           bc_r, bc_nxt;

  // Sequencer and remainder unit
  eng_state_t            st_r, st_nxt;
  cmd_t                  hold_r;
  logic [16:0]           rem_r;
  logic [TIMER_BITS-1:0] dvd_r;
  logic [CNT_W-1:0]      dcnt_r;
  logic                  div_done, fetch_ok, need_div, div_start, apply;
  logic [16:0]           rep_x, rem_t, rem_step;
  logic                  mod_zero;
  cmd_t                  cs;

  assign rep_x    = (cfg.handshake_repeat_ms == 16'd0) ? 17'd1 : {1'b0, cfg.handshake_repeat_ms};
  assign rem_t    = {rem_r[15:0], dvd_r[TIMER_BITS-1]};
  assign rem_step = (rem_t >= rep_x) ? rem_t - rep_x : rem_t;
  assign div_done = (dcnt_r == CNT_W'(TIMER_BITS));
  assign mod_zero = (rem_r == 17'd0);
  assign fetch_ok = (st_r == ENG_FETCH) && cmd_valid && em_free;
  assign need_div = cmd.is_tick && armed_r && !session_r && (ms_arm_r != TMAX);
  assign cs       = (st_r == ENG_DIV) ? hold_r : cmd;

  // Sequencer next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ENG_FETCH: if (fetch_ok && need_div) st_nxt = ENG_DIV;
      ENG_DIV:   if (div_done) st_nxt = ENG_FETCH;
      default:   st_nxt = ENG_FETCH;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd_pop   = 1'b0;
    div_start = 1'b0;
    apply     = 1'b0;
    unique case (st_r)
      ENG_FETCH: begin
        cmd_pop   = fetch_ok;
        div_start = fetch_ok && need_div;
        apply     = fetch_ok && !need_div;
      end
      ENG_DIV: apply = div_done;
      default: ;
    endcase
  end

  assign load = apply;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ENG_FETCH;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Remainder of the advanced window timer by the handshake interval, one bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (div_start) begin
      dcnt_r <= '0;
    end else if ((st_r == ENG_DIV) && !div_done) begin
      dcnt_r <= dcnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      hold_r <= cmd;
      rem_r  <= 17'd0;
      dvd_r  <= ms_arm_r + TIMER_BITS'(1);
    end else if ((st_r == ENG_DIV) && !div_done) begin
      rem_r <= rem_step;
      dvd_r <= dvd_r << 1;
    end
  end

  // Step logic
  logic [IDX_W-1:0]      plen;
  logic [7:0]            b;
  logic [RES_CNT_W-1:0]  n;
  logic                  clr, do_hdr, stream, digit, arm_adv;
  logic [CMP_W-1:0]      arm_x, rx_x, eot2_x;
  logic [15:0]           crc_full;
  logic [35:0]           acc;
  logic [32:0]           bc_sum;
  logic [31:0]           bc_new;
  logic [3:0]            dval;

  assign plen  = long_r ? IDX_W'(LONG_PAYLOAD) : IDX_W'(SHORT_PAYLOAD);
  assign b     = cs.rx_byte;
  assign digit = (b >= 8'h30) && (b <= 8'h39);
  assign dval  = 4'(b - 8'h30);
  assign acc   = ({4'd0, dsize_r} << 3) + ({4'd0, dsize_r} << 1) + 36'(dval);

  always_comb begin
    rx_phase_nxt = rx_phase_r;  long_nxt = long_r;  data_index_nxt = data_index_r;
    skip_nxt = skip_r;  seq_nxt = seq_r;  crc_nxt = crc_r;  crc_rx_nxt = crc_rx_r;
    exp_seq_nxt = exp_seq_r;  fc_nxt = fc_r;  eot_pend_nxt = eot_pend_r;
    session_nxt = session_r;  err_nxt = err_r;  armed_nxt = armed_r;
    prev_can_nxt = prev_can_r;  ms_arm_nxt = ms_arm_r;  ms_rx_nxt = ms_rx_r;
    ms_eot2_nxt = ms_eot2_r;  eot2_nxt = eot2_r;  hp_nxt = hp_r;
    dsize_nxt = dsize_r;  fsize_nxt = fsize_r;  bc_nxt = bc_r;
    lst = '0;  n = '0;  clr = 1'b0;  do_hdr = 1'b0;
    arm_adv = 1'b0;  crc_full = {crc_rx_r[15:8], b};
    stream = session_r && !(fc_r && (seq_r == 8'd0));
    bc_sum = {1'b0, bc_r} + 33'(plen);
    bc_new = bc_sum[32] ? 32'hFFFF_FFFF : bc_sum[31:0];
    arm_x = '0;  rx_x = '0;  eot2_x = '0;

    if (cs.is_tick) begin
      if (armed_r) begin
        // Advance the saturating timers
        arm_adv = (ms_arm_r != TMAX);
        if (arm_adv) ms_arm_nxt = ms_arm_r + TIMER_BITS'(1);
        if (ms_rx_r != TMAX) ms_rx_nxt = ms_rx_r + TIMER_BITS'(1);
        if (ms_eot2_r != TMAX) ms_eot2_nxt = ms_eot2_r + TIMER_BITS'(1);
        arm_x  = CMP_W'(ms_arm_nxt);
        rx_x   = CMP_W'(ms_rx_nxt);
        eot2_x = CMP_W'(ms_eot2_nxt);
        if (!session_r) begin
          if (arm_adv && mod_zero && (arm_x < CMP_W'(cfg.arm_window_ms))) begin
            lst[n[2:0]] = '{KIND_REPLY, C_REQ};  n = n + RES_CNT_W'(1);
          end
          if (arm_x >= CMP_W'(cfg.arm_window_ms)) begin
            armed_nxt = 1'b0;
            lst[n[2:0]] = '{KIND_EVENT, EV_WINDOW};  n = n + RES_CNT_W'(1);
          end
        end else if (fc_r && eot2_r && (eot2_x >= CMP_W'(cfg.end_packet_timeout_ms)) &&
                     (rx_phase_r == PH_HEAD) &&
                     (rx_x >= CMP_W'(cfg.end_packet_timeout_ms))) begin
          lst[n[2:0]] = '{KIND_EVENT, EV_FINISH_NOEND};  n = n + RES_CNT_W'(1);
          lst[n[2:0]] = '{KIND_REPLY, C_REQ};  n = n + RES_CNT_W'(1);
          clr = 1'b1;
        end else if ((rx_x >= CMP_W'(cfg.rx_timeout_ms)) || (err_r > cfg.max_errors)) begin
          lst[n[2:0]] = '{KIND_REPLY, C_CAN};  n = n + RES_CNT_W'(1);
          lst[n[2:0]] = '{KIND_REPLY, C_CAN};  n = n + RES_CNT_W'(1);
          lst[n[2:0]] = '{KIND_EVENT, (rx_x >= CMP_W'(cfg.rx_timeout_ms)) ?
                          EV_RXTIMEOUT : EV_ERRORS};
          n = n + RES_CNT_W'(1);
          lst[n[2:0]] = '{KIND_REPLY, C_REQ};  n = n + RES_CNT_W'(1);
          clr = 1'b1;
        end
      end
    end else if (armed_r) begin
      ms_rx_nxt = '0;
      if ((rx_phase_r == PH_HEAD) && cs.is_can) begin
        // Second CAN in a row cancels
        if (prev_can_r) begin
          lst[n[2:0]] = '{KIND_EVENT, EV_CANCEL};  n = n + RES_CNT_W'(1);
          lst[n[2:0]] = '{KIND_REPLY, C_REQ};  n = n + RES_CNT_W'(1);
          clr = 1'b1;
        end else begin
          prev_can_nxt = 1'b1;
        end
      end else if ((rx_phase_r == PH_HEAD) && cs.is_abort) begin
        lst[n[2:0]] = '{KIND_REPLY, C_CAN};  n = n + RES_CNT_W'(1);
        lst[n[2:0]] = '{KIND_REPLY, C_CAN};  n = n + RES_CNT_W'(1);
        lst[n[2:0]] = '{KIND_EVENT, EV_ABORT};  n = n + RES_CNT_W'(1);
        lst[n[2:0]] = '{KIND_REPLY, C_REQ};  n = n + RES_CNT_W'(1);
        clr = 1'b1;
      end else begin
        prev_can_nxt = 1'b0;
        unique case (rx_phase_r)
          PH_SEQ: begin
            seq_nxt = b;
            rx_phase_nxt = PH_SEQINV;
          end
          PH_SEQINV: begin
            if ((seq_r ^ b) != 8'hFF) begin
              lst[n[2:0]] = '{KIND_REPLY, C_NAK};  n = n + RES_CNT_W'(1);
              skip_nxt = plen + IDX_W'(2);
              rx_phase_nxt = PH_SKIP;
            end else begin
              crc_nxt = 16'd0;
              hp_nxt = HP_NAME;
              dsize_nxt = 32'd0;
              skip_nxt = '0;
              rx_phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            crc_nxt = crc16_byte(crc_r, b);
            if (stream) begin
              lst[n[2:0]] = '{KIND_PAYLOAD, b};  n = n + RES_CNT_W'(1);
            end else begin
              // Header: name, then decimal size
              case (hp_r)
                HP_NAME: begin
                  if (b == 8'h00) begin
                    if (data_index_r == '0) skip_nxt = IDX_W'(1);
                    if ((data_index_r + IDX_W'(1)) < plen) hp_nxt = HP_SPACE;
                  end
                end
                HP_SPACE: begin
                  if ((b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D))) begin
                    hp_nxt = HP_SPACE;
                  end else if (b == 8'h2B) begin
                    hp_nxt = HP_DIGITS;
                  end else if (digit) begin
                    dsize_nxt = 32'(dval);
                    hp_nxt = HP_DIGITS;
                  end else begin
                    if (b == 8'h2D) dsize_nxt = 32'd0;
                    hp_nxt = HP_DONE;
                  end
                end
                HP_DIGITS: begin
                  if (digit) begin
                    dsize_nxt = (acc[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc[31:0];
                  end else begin
                    hp_nxt = HP_DONE;
                  end
                end
                default: ;
              endcase
            end
            data_index_nxt = data_index_r + IDX_W'(1);
            if (data_index_nxt >= plen) rx_phase_nxt = PH_CRCHI;
          end
          PH_CRCHI: begin
            crc_rx_nxt = {b, 8'h00};
            rx_phase_nxt = PH_CRCLO;
          end
          PH_CRCLO: begin
            crc_rx_nxt = crc_full;
            rx_phase_nxt = PH_HEAD;
            // Close the packet
            if (crc_r != crc_full) begin
              if (stream) begin
                lst[n[2:0]] = '{KIND_EVENT, EV_DISCARD};  n = n + RES_CNT_W'(1);
              end
              lst[n[2:0]] = '{KIND_REPLY, C_NAK};  n = n + RES_CNT_W'(1);
              if (session_r && (err_r != 8'hFF)) err_nxt = err_r + 8'd1;
            end else if (fc_r && (seq_r == 8'd0)) begin
              do_hdr = 1'b1;
            end else if (seq_r == (exp_seq_r - 8'd1)) begin
              if (stream) begin
                lst[n[2:0]] = '{KIND_EVENT, EV_DISCARD};  n = n + RES_CNT_W'(1);
              end
              lst[n[2:0]] = '{KIND_REPLY, C_ACK};  n = n + RES_CNT_W'(1);
            end else if (seq_r != exp_seq_r) begin
              if (stream) begin
                lst[n[2:0]] = '{KIND_EVENT, EV_DISCARD};  n = n + RES_CNT_W'(1);
              end
              lst[n[2:0]] = '{KIND_REPLY, C_NAK};  n = n + RES_CNT_W'(1);
              if (session_r && (err_r != 8'hFF)) err_nxt = err_r + 8'd1;
            end else begin
              err_nxt = 8'd0;
              if (!stream) begin
                do_hdr = 1'b1;
              end else begin
                lst[n[2:0]] = '{KIND_EVENT, EV_COMMIT};  n = n + RES_CNT_W'(1);
                lst[n[2:0]] = '{KIND_REPLY, C_ACK};  n = n + RES_CNT_W'(1);
                exp_seq_nxt = exp_seq_r + 8'd1;
                bc_nxt = bc_new;
                if (bc_new >= 32'(fsize_r)) fc_nxt = 1'b1;
              end
            end
          end
          PH_SKIP: begin
            if (skip_r != '0) skip_nxt = skip_r - IDX_W'(1);
            if (skip_nxt == '0) begin
              rx_phase_nxt = PH_HEAD;
              if (session_r && (err_r != 8'hFF)) err_nxt = err_r + 8'd1;
            end
          end
          default: begin
            if (cs.is_start) begin
              long_nxt = (b == C_STX);
              data_index_nxt = '0;
              rx_phase_nxt = PH_SEQ;
            end else if (cs.is_eot && fc_r) begin
              if (eot_pend_r) begin
                eot_pend_nxt = 1'b0;
                lst[n[2:0]] = '{KIND_REPLY, C_NAK};  n = n + RES_CNT_W'(1);
              end else begin
                lst[n[2:0]] = '{KIND_REPLY, C_ACK};  n = n + RES_CNT_W'(1);
                lst[n[2:0]] = '{KIND_REPLY, C_REQ};  n = n + RES_CNT_W'(1);
                eot2_nxt = 1'b1;
                ms_eot2_nxt = '0;
              end
            end
          end
        endcase

        // Header packet verdict
        if (do_hdr) begin
          if (skip_r == IDX_W'(1)) begin
            lst[n[2:0]] = '{KIND_REPLY, C_ACK};  n = n + RES_CNT_W'(1);
            lst[n[2:0]] = '{KIND_REPLY, C_CAN};  n = n + RES_CNT_W'(1);
            lst[n[2:0]] = '{KIND_REPLY, C_CAN};  n = n + RES_CNT_W'(1);
            lst[n[2:0]] = '{KIND_EVENT, EV_FINISH};  n = n + RES_CNT_W'(1);
            lst[n[2:0]] = '{KIND_REPLY, C_REQ};  n = n + RES_CNT_W'(1);
            clr = 1'b1;
          end else if (hp_r == HP_NAME) begin
            lst[n[2:0]] = '{KIND_REPLY, C_NAK};  n = n + RES_CNT_W'(1);
          end else if ((dsize_r == 32'd0) || (dsize_r > 32'(cfg.image_limit_bytes))) begin
            lst[n[2:0]] = '{KIND_REPLY, C_ACK};  n = n + RES_CNT_W'(1);
            lst[n[2:0]] = '{KIND_REPLY, C_CAN};  n = n + RES_CNT_W'(1);
            lst[n[2:0]] = '{KIND_REPLY, C_CAN};  n = n + RES_CNT_W'(1);
            lst[n[2:0]] = '{KIND_EVENT, EV_STARTFAIL};  n = n + RES_CNT_W'(1);
            lst[n[2:0]] = '{KIND_REPLY, C_REQ};  n = n + RES_CNT_W'(1);
            clr = 1'b1;
          end else begin
            lst[n[2:0]] = '{KIND_REPLY, C_ACK};  n = n + RES_CNT_W'(1);
            lst[n[2:0]] = '{KIND_REPLY, C_REQ};  n = n + RES_CNT_W'(1);
            lst[n[2:0]] = '{KIND_EVENT, EV_START};  n = n + RES_CNT_W'(1);
            fsize_nxt = dsize_r[24:0];
            bc_nxt = 32'd0;
            fc_nxt = 1'b0;
            eot_pend_nxt = 1'b1;
            eot2_nxt = 1'b0;
            exp_seq_nxt = 8'd1;
            session_nxt = 1'b1;
          end
        end
      end
    end

    // Drop the session and reopen the window
    if (clr) begin
      rx_phase_nxt = PH_HEAD;  long_nxt = 1'b0;  data_index_nxt = '0;  skip_nxt = '0;
      seq_nxt = 8'd0;  crc_nxt = 16'd0;  crc_rx_nxt = 16'd0;  exp_seq_nxt = 8'd0;
      fc_nxt = 1'b0;  eot_pend_nxt = 1'b1;  session_nxt = 1'b0;  err_nxt = 8'd0;
      armed_nxt = 1'b1;  prev_can_nxt = 1'b0;  ms_arm_nxt = '0;  ms_rx_nxt = '0;
      ms_eot2_nxt = '0;  eot2_nxt = 1'b0;  hp_nxt = HP_NAME;  dsize_nxt = 32'd0;
      fsize_nxt = 25'd0;  bc_nxt = 32'd0;
    end
  end

  assign lst_n = n;

  // Hold state between steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_phase_r <= PH_HEAD;  long_r <= 1'b0;  data_index_r <= '0;  skip_r <= '0;
      seq_r <= 8'd0;  crc_r <= 16'd0;  crc_rx_r <= 16'd0;  exp_seq_r <= 8'd0;
      fc_r <= 1'b0;  eot_pend_r <= 1'b1;  session_r <= 1'b0;  err_r <= 8'd0;
      armed_r <= 1'b1;  prev_can_r <= 1'b0;  ms_arm_r <= '0;  ms_rx_r <= '0;
      ms_eot2_r <= '0;  eot2_r <= 1'b0;  hp_r <= HP_NAME;  dsize_r <= 32'd0;
      fsize_r <= 25'd0;  bc_r <= 32'd0;
    end else if (apply) begin
      rx_phase_r <= rx_phase_nxt;  long_r <= long_nxt;  data_index_r <= data_index_nxt;
      skip_r <= skip_nxt;  seq_r <= seq_nxt;  crc_r <= crc_nxt;  crc_rx_r <= crc_rx_nxt;
      exp_seq_r <= exp_seq_nxt;  fc_r <= fc_nxt;  eot_pend_r <= eot_pend_nxt;
      session_r <= session_nxt;  err_r <= err_nxt;  armed_r <= armed_nxt;
      prev_can_r <= prev_can_nxt;  ms_arm_r <= ms_arm_nxt;  ms_rx_r <= ms_rx_nxt;
      ms_eot2_r <= ms_eot2_nxt;  eot2_r <= eot2_nxt;  hp_r <= hp_nxt;
      dsize_r <= dsize_nxt;  fsize_r <= fsize_nxt;  bc_r <= bc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_session_armed: assert property (@(posedge clk) disable iff (!rst_n)
    session_r |-> armed_r) else $error("session open with window closed");
  a_complete_in_session: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r |-> session_r) else $error("file complete outside a session");
  a_data_index: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_phase_r == PH_DATA) |-> (data_index_r < plen)) else $error("data index overrun");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> em_free) else $error("result list loaded while busy");
  a_div_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ENG_DIV) |-> (!session_r && armed_r)) else $error("remainder run in session");
`endif

endmodule

// ===== rtl/ymodem_crc_receiver.sv =====
// Top level of the YMODEM-CRC receiver: configuration registers and wiring.
// Depends on ymcr_pkg, ymcr_front, ymcr_engine and ymcr_emit.
//
// Usage: push received bytes (in_func 0) and one-millisecond ticks (in_func 1)
// on the in_ channel. Each word yields zero or more result words on the out_
// channel: payload bytes (kind 0), reply bytes to transmit (kind 1) and
// session events (kind 2); out_last marks the final word of one input word.
// Configuration writes go through cfg_ (always ready), index per register list.
// Flow: the engine takes a new input word only when the result stage is free
// or handing out its last word, at one word a cycle while out_ready is high;
// a tick while the window is open and no session runs first holds the engine
// for the bit-serial remainder against the handshake interval.
// The input word is registered in the input queue, then its results in the result stage.
// A four-word input queue keeps accepting while results wait to be taken;
// a stalled receiver fills it and then drops in_ready.
// Reset: all state returns to window-open idle; nothing is sent until the
// first handshake interval elapses.
module ymodem_crc_receiver import ymcr_pkg::*; #(
  parameter int LONG_PAYLOAD = LONG_PAYLOAD_DEF,
  parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_value,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  cfg_t                 cfg_r;
  logic                 cmd_valid, cmd_pop, em_free, load;
  cmd_t                 cmd;
  res_t [MAX_RES-1:0]   lst;
  logic [RES_CNT_W-1:0] lst_n;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_errors            <= 8'd5;
      cfg_r.rx_timeout_ms         <= 16'd5000;
      cfg_r.end_packet_timeout_ms <= 16'd3000;
      cfg_r.arm_window_ms         <= 16'd10000;
      cfg_r.handshake_repeat_ms   <= 16'd1000;
      cfg_r.image_limit_bytes     <= 25'd1048576;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_ERRORS: cfg_r.max_errors            <= cfg_data[7:0];
        CFG_RX_TO:      cfg_r.rx_timeout_ms         <= cfg_data[15:0];
        CFG_END_TO:     cfg_r.end_packet_timeout_ms <= cfg_data[15:0];
        CFG_ARM_WIN:    cfg_r.arm_window_ms         <= cfg_data[15:0];
        CFG_HS_REPEAT:  cfg_r.handshake_repeat_ms   <= cfg_data[15:0];
        CFG_IMG_LIMIT:  cfg_r.image_limit_bytes     <= cfg_data;
        default: ;
      endcase
    end
  end

  ymcr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_rx_byte (in_rx_byte),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  ymcr_engine #(
    .LONG_PAYLOAD (LONG_PAYLOAD),
    .TIMER_BITS   (TIMER_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .em_free   (em_free),
    .load      (load),
    .lst       (lst),
    .lst_n     (lst_n)
  );

  ymcr_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .lst       (lst),
    .lst_n     (lst_n),
    .em_free   (em_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule
